// ===== rtl/msbbp_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, result type and width clamp for the MSB-first bit packer.
// No dependencies.

package msbbp_pkg;

    localparam int WORD_BITS  = 32;
    localparam int VALUE_W    = 16;
    localparam int WIDTH_W    = 5;
    localparam int FREE_W     = 6;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W     = 2;
    localparam int QCNT_W     = 3;

    localparam logic [WIDTH_W-1:0] BPV_RESET = WIDTH_W'(16);
    localparam logic [WIDTH_W-1:0] BPV_MAX   = WIDTH_W'(16);
    localparam logic [WIDTH_W-1:0] BPV_MIN   = WIDTH_W'(1);
    localparam logic [FREE_W-1:0]  FREE_FULL = FREE_W'(WORD_BITS);

    typedef struct packed {
        logic [WORD_BITS-1:0] packed_word;
        logic                 end_of_stream;
    } result_t;

    // saturate the programmed width into 1..16
    function automatic logic [WIDTH_W-1:0] clamp_width(input logic [WIDTH_W-1:0] w);
        logic [WIDTH_W-1:0] r;
        if (w == '0)
            r = BPV_MIN;
        else if (w > BPV_MAX)
            r = BPV_MAX;
        else
            r = w;
        return r;
    endfunction

endpackage

// ===== rtl/msb_first_bit_packer_top.sv =====
`timescale 1ns / 1ps
// Top level of the MSB-first variable-width bit packer.
// Depends on msbbp_pkg.

// Takes one 16-bit value per cycle while s_tready is high and packs its low
// bits_per_value bits (0 reads as 1, 17..31 as 16) MSB first into 32-bit
// words, bit 31 first. A full word leaves on m_tdata; the value marked by
// s_tlast flushes the partial word left-aligned with zero padding and marks
// it with m_tlast, after which packing restarts from an empty word. Each
// accepted transaction updates the accumulator in the same cycle and writes
// its zero, one or two words into a four-entry output queue; the first word
// is visible in the cycle after acceptance. The input side sustains one
// transaction per cycle while s_tready is high and the output side one word
// per cycle while m_tready is high. s_tready is low while the queue has fewer
// than two free entries. cfg_ready is always high; write bits_per_value only
// while the stream is idle.
module msb_first_bit_packer_top (
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [4:0]  cfg_data,   // [4:0] bits_per_value
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // [15:0] value
    input  logic        s_tlast,    // last_value
    // output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // [31:0] packed_word
    output logic        m_tlast     // end_of_stream
);

    localparam int WB = msbbp_pkg::WORD_BITS;
    localparam int VW = msbbp_pkg::VALUE_W;
    localparam int NW = msbbp_pkg::WIDTH_W;
    localparam int FW = msbbp_pkg::FREE_W;
    localparam int PW = msbbp_pkg::QPTR_W;
    localparam int CW = msbbp_pkg::QCNT_W;

    logic [NW-1:0]   bpv_reg;
    logic [WB-1:0]   acc_reg, acc_next;
    logic [FW-1:0]   free_reg, free_next;

    msbbp_pkg::result_t queue_reg [msbbp_pkg::QUEUE_DEPTH];
    logic [PW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]   count_reg, count_next;

    logic            in_fire, out_fire;
    logic [NW-1:0]   n;
    logic [VW:0]     mask_wide;
    logic [VW-1:0]   v;
    logic [WB-1:0]   v_ext;
    logic            fill;
    logic [3:0]      rest;
    logic [FW-1:0]   carry_free;
    logic [WB-1:0]   word0, carry_acc, merged_acc;
    msbbp_pkg::result_t res0, res1;
    logic [1:0]      push_n;

    assign cfg_ready = 1'b1;
    assign in_fire   = s_tvalid && s_tready;
    assign out_fire  = m_tvalid && m_tready;
    assign s_tready  = (count_reg <= CW'(msbbp_pkg::QUEUE_DEPTH - 2));
    assign m_tvalid  = (count_reg != '0);
    assign m_tdata   = queue_reg[rd_ptr_reg].packed_word;
    assign m_tlast   = queue_reg[rd_ptr_reg].end_of_stream;

    always_comb
    begin
        n          = msbbp_pkg::clamp_width(bpv_reg);
        mask_wide  = (17'd1 << n) - 17'd1;
        v          = s_tdata & mask_wide[VW-1:0];
        v_ext      = {{(WB-VW){1'b0}}, v};
        fill       = ({1'b0, n} >= free_reg);
        rest       = 4'(({1'b0, n} - free_reg));
        carry_free = FW'(WB) - {2'b00, rest};
        word0      = acc_reg | (v_ext >> rest);
        carry_acc  = (rest == '0) ? '0 : (v_ext << carry_free);
        merged_acc = acc_reg | (v_ext << (free_reg - {1'b0, n}));

        res0       = '0;
        res1       = '0;
        push_n     = 2'd0;
        acc_next   = acc_reg;
        free_next  = free_reg;

        if (in_fire)
        begin
            if (fill)
            begin
                res0.packed_word   = word0;
                res0.end_of_stream = s_tlast && (rest == '0);
                res1.packed_word   = carry_acc;
                res1.end_of_stream = 1'b1;
                push_n             = (s_tlast && (rest != '0)) ? 2'd2 : 2'd1;
                acc_next           = carry_acc;
                free_next          = carry_free;
            end
            else
            begin
                res0.packed_word   = merged_acc;
                res0.end_of_stream = 1'b1;
                push_n             = s_tlast ? 2'd1 : 2'd0;
                acc_next           = merged_acc;
                free_next          = free_reg - {1'b0, n};
            end
            if (s_tlast)
            begin
                acc_next  = '0;
                free_next = msbbp_pkg::FREE_FULL;
            end
        end

        count_next = count_reg + CW'(push_n) - CW'(out_fire);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bpv_reg    <= msbbp_pkg::BPV_RESET;
            acc_reg    <= '0;
            free_reg   <= msbbp_pkg::FREE_FULL;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                bpv_reg <= cfg_data;
            acc_reg    <= acc_next;
            free_reg   <= free_next;
            wr_ptr_reg <= wr_ptr_reg + PW'(push_n);
            if (out_fire)
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
            queue_reg[wr_ptr_reg] <= res0;
        if (push_n == 2'd2)
            queue_reg[wr_ptr_reg + PW'(1)] <= res1;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(msbbp_pkg::QUEUE_DEPTH))
        else $error("output queue overflow");

    assert property (@(posedge clk) disable iff (!rst_n)
        (free_reg != '0) && (free_reg <= msbbp_pkg::FREE_FULL))
        else $error("free bit count out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tlast) |=> (m_tvalid && (free_reg == msbbp_pkg::FREE_FULL)))
        else $error("last transaction did not flush");

    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> m_tvalid)
        else $error("queued word lost");

endmodule
